// ----- design/abkf_pkg.sv -----
// ----------------------------------------------------------------------------
// abkf_pkg
// shared types and constants of the angle and gyro-bias kalman filter
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int DEF_DATA_WIDTH = 32;

  localparam int IO_W    = 32;  // angle, rate and bias words on the ports
  localparam int DT_W    = 16;  // time step, unsigned q0.16
  localparam int NOISE_W = 31;  // noise registers, unsigned q7.24
  localparam int GAIN_W  = 32;  // gains, signed q8.24
  localparam int CFG_IDX_W = 2;

  localparam logic [NOISE_W-1:0] APN_RESET = 31'd16777;
  localparam logic [NOISE_W-1:0] BPN_RESET = 31'd50332;
  localparam logic [NOISE_W-1:0] MN_RESET  = 31'd503316;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_M_ANG,
    ST_M_DTP,
    ST_INNER,
    ST_M_PAA,
    ST_M_PBB,
    ST_GAIN,
    ST_D_K0,
    ST_D_K1,
    ST_Y,
    ST_M_A,
    ST_M_B,
    ST_M_PBA,
    ST_M_PBB2,
    ST_M_PAA2,
    ST_M_PAB,
    ST_DONE
  } abkf_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } abkf_unit_st_t;

endpackage

// ----- design/angle_bias_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// two-state angle / gyro-bias kalman filter on one shared multiplier and
// one serial divider under a small sequencer
// ----------------------------------------------------------------------------
// work per word: the ten multiplies through the 8-bit-per-cycle multiplier and
//   the two 32-step gain divisions; a saturating gain is set at once without the
//   serial steps, and a gain fault skips the divisions and the correction
// input: ready only while the sequencer idles, so a new word waits until the
//   last result is loaded into the output register, and an output stall holds it
// reset: async active low, clears estimates and covariance to zero and loads
//   the noise registers with their defaults
module angle_bias_kalman_filter
  import abkf_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [79:0]          s_axis_tdata,   // measured_angle, measured_rate, time_step
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // filtered_angle, estimated_bias
  output logic                 m_axis_tuser,   // gain_fault
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [NOISE_W-1:0]   cfg_data_i
);

  localparam int DW  = DATA_WIDTH;
  localparam int OpW = ((DW > 32) ? DW : 32) + 1;   // multiplier / divider operands
  localparam int SW  = OpW + 3;                     // exact sums before saturation
  localparam int W2  = OpW - 1;                     // common width for the 32-bit clamp
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [W2-1:0] O_HI   = {{(W2-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [W2-1:0] O_LO   = ~O_HI;

  // saturate an exact sum to the state width
  function automatic logic signed [DW-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[DW-1:0];
    else if (v < SAT_LO) r = SAT_LO[DW-1:0];
    else                 r = v[DW-1:0];
    return r;
  endfunction

  // clamp a state word to the 32-bit port width
  function automatic logic [IO_W-1:0] sat_o(input logic signed [DW-1:0] v);
    logic signed [W2-1:0] e;
    logic [IO_W-1:0]      r;
    e = W2'(v);
    if (e > O_HI)      r = O_HI[IO_W-1:0];
    else if (e < O_LO) r = O_LO[IO_W-1:0];
    else               r = e[IO_W-1:0];
    return r;
  endfunction

  abkf_state_e state_q, state_d;

  // noise registers
  logic [NOISE_W-1:0] apn_q, bpn_q, mn_q;

  // filter state
  logic signed [DW-1:0] ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
  // per-word working registers
  logic signed [IO_W-1:0]   z_q, w_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [DW-1:0]     rate_q, dtp_q, inner_q, y_q;
  logic signed [OpW-1:0]    s_q;
  logic signed [GAIN_W-1:0] k0_q, k1_q;
  logic                     fault_q;
  logic                     issued_q, issued_d;

  // output register
  logic              out_valid_q;
  logic [IO_W-1:0]   out_ang_q, out_bias_q;
  logic              out_fault_q;

  // shared units
  logic                  mul_start, mul_sh16;
  logic signed [OpW-1:0] mul_a, mul_b;
  abkf_unit_st_t         mul_st;
  logic signed [DW-1:0]  mul_res;
  logic                  div_start;
  logic signed [DW-1:0]  div_num;
  abkf_unit_st_t         div_st;
  logic signed [GAIN_W-1:0] div_quo;

  logic in_acc, out_load;
  logic signed [OpW-1:0] s_c;

  // operand views
  logic signed [OpW-1:0] dt_op, bpn_op;
  assign dt_op  = signed'(OpW'(dt_q));
  assign bpn_op = signed'(OpW'(bpn_q));
  assign s_c    = OpW'(paa_q) + signed'(OpW'(mn_q));

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  abkf_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh16_i  (mul_sh16),
    .st_o    (mul_st),
    .res_o   (mul_res)
  );

  abkf_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_q),
    .st_o    (div_st),
    .quo_o   (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_RATE;
      ST_RATE:   state_d = ST_M_ANG;
      ST_M_ANG:  if (mul_st.done) state_d = ST_M_DTP;
      ST_M_DTP:  if (mul_st.done) state_d = ST_INNER;
      ST_INNER:  state_d = ST_M_PAA;
      ST_M_PAA:  if (mul_st.done) state_d = ST_M_PBB;
      ST_M_PBB:  if (mul_st.done) state_d = ST_GAIN;
      // a non-positive innovation variance skips the whole correction
      ST_GAIN:   state_d = (s_c <= 0) ? ST_DONE : ST_D_K0;
      ST_D_K0:   if (div_st.done) state_d = ST_D_K1;
      ST_D_K1:   if (div_st.done) state_d = ST_Y;
      ST_Y:      state_d = ST_M_A;
      ST_M_A:    if (mul_st.done) state_d = ST_M_B;
      ST_M_B:    if (mul_st.done) state_d = ST_M_PBA;
      ST_M_PBA:  if (mul_st.done) state_d = ST_M_PBB2;
      ST_M_PBB2: if (mul_st.done) state_d = ST_M_PAA2;
      ST_M_PAA2: if (mul_st.done) state_d = ST_M_PAB;
      ST_M_PAB:  if (mul_st.done) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_sh16  = 1'b1;
    mul_a     = dt_op;
    mul_b     = OpW'(rate_q);
    div_start = 1'b0;
    div_num   = paa_q;
    s_axis_tready = (state_q == ST_IDLE);
    case (state_q)
      ST_M_ANG:  begin mul_start = !issued_q; mul_b = OpW'(rate_q); end
      ST_M_DTP:  begin mul_start = !issued_q; mul_b = OpW'(pbb_q); end
      ST_M_PAA:  begin mul_start = !issued_q; mul_b = OpW'(inner_q); end
      ST_M_PBB:  begin mul_start = !issued_q; mul_a = bpn_op; mul_b = dt_op; end
      ST_D_K0:   begin div_start = !issued_q; div_num = paa_q; end
      ST_D_K1:   begin div_start = !issued_q; div_num = pba_q; end
      ST_M_A: begin
        mul_start = !issued_q; mul_sh16 = 1'b0;
        mul_a = OpW'(k0_q); mul_b = OpW'(y_q);
      end
      ST_M_B: begin
        mul_start = !issued_q; mul_sh16 = 1'b0;
        mul_a = OpW'(k1_q); mul_b = OpW'(y_q);
      end
      ST_M_PBA: begin
        mul_start = !issued_q; mul_sh16 = 1'b0;
        mul_a = OpW'(k1_q); mul_b = OpW'(paa_q);
      end
      ST_M_PBB2: begin
        mul_start = !issued_q; mul_sh16 = 1'b0;
        mul_a = OpW'(k1_q); mul_b = OpW'(pab_q);
      end
      ST_M_PAA2: begin
        mul_start = !issued_q; mul_sh16 = 1'b0;
        mul_a = OpW'(k0_q); mul_b = OpW'(paa_q);
      end
      ST_M_PAB: begin
        mul_start = !issued_q; mul_sh16 = 1'b0;
        mul_a = OpW'(k0_q); mul_b = OpW'(pab_q);
      end
      default: ;
    endcase
  end

  // one start per unit step, cleared when the unit reports done
  always_comb begin
    if (mul_start || div_start)        issued_d = 1'b1;
    else if (mul_st.done || div_st.done) issued_d = 1'b0;
    else                               issued_d = issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      apn_q       <= APN_RESET;
      bpn_q       <= BPN_RESET;
      mn_q        <= MN_RESET;
      ang_q       <= '0;
      bias_q      <= '0;
      paa_q       <= '0;
      pab_q       <= '0;
      pba_q       <= '0;
      pbb_q       <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (out_load)                          out_valid_q <= 1'b1;
      else if (m_axis_tready)                out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ANGLE_NOISE: apn_q <= cfg_data_i;
          REG_BIAS_NOISE:  bpn_q <= cfg_data_i;
          REG_MEAS_NOISE:  mn_q  <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_M_ANG:  if (mul_st.done) ang_q <= sat_w(SW'(ang_q) + SW'(mul_res));
        ST_INNER: begin
          pab_q <= sat_w(SW'(pab_q) - SW'(dtp_q));
          pba_q <= sat_w(SW'(pba_q) - SW'(dtp_q));
        end
        ST_M_PAA:  if (mul_st.done) paa_q <= sat_w(SW'(paa_q) + SW'(mul_res));
        ST_M_PBB:  if (mul_st.done) pbb_q <= sat_w(SW'(pbb_q) + SW'(mul_res));
        ST_M_A:    if (mul_st.done) ang_q <= sat_w(SW'(ang_q) + SW'(mul_res));
        ST_M_B:    if (mul_st.done) bias_q <= sat_w(SW'(bias_q) + SW'(mul_res));
        ST_M_PBA:  if (mul_st.done) pba_q <= sat_w(SW'(pba_q) - SW'(mul_res));
        ST_M_PBB2: if (mul_st.done) pbb_q <= sat_w(SW'(pbb_q) - SW'(mul_res));
        ST_M_PAA2: if (mul_st.done) paa_q <= sat_w(SW'(paa_q) - SW'(mul_res));
        ST_M_PAB:  if (mul_st.done) pab_q <= sat_w(SW'(pab_q) - SW'(mul_res));
        default: ;
      endcase
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q  <= s_axis_tdata[31:0];
      w_q  <= s_axis_tdata[63:32];
      dt_q <= s_axis_tdata[79:64];
    end
    case (state_q)
      ST_RATE:  rate_q <= sat_w(SW'(w_q) - SW'(bias_q));
      ST_M_DTP: if (mul_st.done) dtp_q <= mul_res;
      // predicted angle variance growth uses the covariance before the update
      ST_INNER: inner_q <= sat_w(SW'(dtp_q) - SW'(pab_q) - SW'(pba_q)
                                 + signed'(SW'(apn_q)));
      ST_GAIN: begin
        s_q     <= s_c;
        fault_q <= (s_c <= 0);
      end
      ST_D_K0:  if (div_st.done) k0_q <= div_quo;
      ST_D_K1:  if (div_st.done) k1_q <= div_quo;
      ST_Y:     y_q <= sat_w(SW'(z_q) - SW'(ang_q));
      default: ;
    endcase
    if (out_load) begin
      out_ang_q   <= sat_o(ang_q);
      out_bias_q  <= sat_o(bias_q);
      out_fault_q <= fault_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_bias_q, out_ang_q};
  assign m_axis_tuser  = out_fault_q;

`ifndef SYNTHESIS
  a_mul_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy)
    else $error("multiplier started while busy");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mul_st.busy && !div_st.busy && !issued_q))
    else $error("shared unit active while sequencer idle");

  a_div_done_in_div_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_D_K0 || state_q == ST_D_K1))
    else $error("divider result outside a gain step");
`endif

endmodule

// ----- design/abkf_mul.sv -----
// ----------------------------------------------------------------------------
// abkf_mul
// shared multiplier: 8 bits of the second operand per cycle, then round
// half away from zero, shift and saturate to DATA_WIDTH bits
// ----------------------------------------------------------------------------
module abkf_mul
  import abkf_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int OpW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [OpW-1:0]              a_i,
  input  logic signed [OpW-1:0]              b_i,
  input  logic                               sh16_i,   // 1: shift 16, 0: shift 24
  output abkf_unit_st_t                      st_o,
  output logic signed [DATA_WIDTH-1:0]       res_o
);

  localparam int PW   = 2 * OpW;
  localparam int ND   = (OpW + 7) / 8;
  localparam int CW   = $clog2(ND + 1);
  localparam logic [PW:0] LIM_POS = {{(PW-DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [PW:0] LIM_NEG = LIM_POS + 1'b1;
  localparam logic [PW:0] RND16   = (PW+1)'(1) << 15;
  localparam logic [PW:0] RND24   = (PW+1)'(1) << 23;

  logic [PW-1:0]  ua_q, ua_d;
  logic [OpW-1:0] ub_q, ub_d;
  logic [PW-1:0]  acc_q, acc_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           fin_q, fin_d;
  logic           done_q, done_d;
  logic           neg_q, neg_d;
  logic           sh16_q, sh16_d;
  logic signed [DATA_WIDTH-1:0] res_q, res_d;

  logic [OpW-1:0] a_mag;
  logic [PW+7:0]  pp;
  logic [PW:0]    rnd, shf, lim, mag;

  always_comb begin
    a_mag  = a_i[OpW-1] ? OpW'(~a_i + 1'b1) : OpW'(a_i);
    pp     = ua_q * ub_q[7:0];
    rnd    = {1'b0, acc_q} + (sh16_q ? RND16 : RND24);
    shf    = sh16_q ? (rnd >> 16) : (rnd >> 24);
    lim    = neg_q ? LIM_NEG : LIM_POS;
    mag    = (shf > lim) ? lim : shf;

    ua_d   = ua_q;
    ub_d   = ub_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    neg_d  = neg_q;
    sh16_d = sh16_q;
    res_d  = res_q;

    if (start_i && !busy_q) begin
      ua_d   = PW'(a_mag);
      ub_d   = b_i[OpW-1] ? OpW'(~b_i + 1'b1) : OpW'(b_i);
      neg_d  = a_i[OpW-1] ^ b_i[OpW-1];
      sh16_d = sh16_i;
      acc_d  = '0;
      cnt_d  = CW'(ND);
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != '0) begin
      acc_d = acc_q + pp[PW-1:0];
      ua_d  = ua_q << 8;
      ub_d  = ub_q >> 8;
      cnt_d = cnt_q - 1'b1;
      fin_d = (cnt_q == CW'(1));
    end else if (fin_q) begin
      res_d  = neg_q ? DATA_WIDTH'(~mag + 1'b1) : DATA_WIDTH'(mag);
      done_d = 1'b1;
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q   <= ua_d;
    ub_q   <= ub_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    sh16_q <= sh16_d;
    res_q  <= res_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign res_o     = res_q;

endmodule

// ----- design/abkf_div.sv -----
// ----------------------------------------------------------------------------
// abkf_div
// serial restoring divider for the gains: trunc(num * 2^24 / den),
// one quotient bit per cycle, saturated to 32-bit signed
// ----------------------------------------------------------------------------
module abkf_div
  import abkf_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int OpW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [DATA_WIDTH-1:0]  num_i,
  input  logic signed [OpW-1:0]         den_i,   // positive
  output abkf_unit_st_t                 st_o,
  output logic signed [GAIN_W-1:0]      quo_o
);

  localparam int CW  = $clog2(GAIN_W + 1);

  logic [OpW-1:0]    d_q, d_d;
  logic [OpW-1:0]    r_q, r_d;
  logic [GAIN_W-1:0] nb_q, nb_d;
  logic [GAIN_W-1:0] q_q, q_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic signed [GAIN_W-1:0] quo_q, quo_d;

  logic [DATA_WIDTH-1:0] n_mag;
  logic [OpW:0]          r2;
  logic [OpW+7:0]        d_sh;
  logic [GAIN_W:0]       lim;
  logic                  ovf;

  always_comb begin
    n_mag = num_i[DATA_WIDTH-1] ? DATA_WIDTH'(~num_i + 1'b1) : DATA_WIDTH'(num_i);
    d_sh  = {den_i, 8'b0};
    ovf   = ((OpW+8)'(n_mag) >= d_sh);
    r2    = {r_q, nb_q[GAIN_W-1]};
    lim   = neg_q ? (GAIN_W+1)'(33'h080000000) : (GAIN_W+1)'(33'h07fffffff);

    d_d    = d_q;
    r_d    = r_q;
    nb_d   = nb_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    quo_d  = quo_q;

    if (start_i && !busy_q) begin
      neg_d = num_i[DATA_WIDTH-1];
      d_d   = OpW'(den_i);
      r_d   = OpW'(n_mag >> 8);
      nb_d  = {n_mag[7:0], 24'b0};
      q_d   = '0;
      if (ovf) begin
        // quotient reaches 2^32: saturate at once
        quo_d  = num_i[DATA_WIDTH-1] ? GAIN_W'(32'h80000000) : GAIN_W'(32'h7fffffff);
        done_d = 1'b1;
      end else begin
        cnt_d  = CW'(GAIN_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (r2 >= {1'b0, d_q}) begin
        r_d = OpW'(r2 - {1'b0, d_q});
        q_d = {q_q[GAIN_W-2:0], 1'b1};
      end else begin
        r_d = OpW'(r2);
        q_d = {q_q[GAIN_W-2:0], 1'b0};
      end
      nb_d  = nb_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if ({1'b0, q_d} > lim) begin
          quo_d = neg_q ? GAIN_W'(32'h80000000) : GAIN_W'(32'h7fffffff);
        end else begin
          quo_d = neg_q ? GAIN_W'(~q_d + 1'b1) : GAIN_W'(q_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    r_q   <= r_d;
    nb_q  <= nb_d;
    q_q   <= q_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quo_o     = quo_q;

endmodule

// ----- sim/angle_bias_kalman_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_tb
// self-checking bench for the angle / gyro-bias kalman filter: a fixed-point
// filter model predicts every output word, random gaps and stalls on both
// streams, noise registers changed between phases while the filter is idle
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_tb
  import abkf_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int     DRAIN_CYCLES = 400;   // longer than one word's pass through the filter
  localparam int     LONG_HOLD = 3000;     // receiver hold-off under pressure

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] bias;
    logic        fault;
  } filt_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [NOISE_W-1:0]   cfg_data_i = '0;

  angle_bias_kalman_filter dut (.*);

  always #2 clk_i = ~clk_i;

  // filter model state, q16.16 estimates and q8.24 covariance
  longint q_ang, q_bias;
  longint p_aa, p_ab, p_ba, p_bb;
  longint n_ang, n_bias, n_meas;   // noise registers

  filt_out_t expected_q[$];
  int        errors = 0;
  int        stall_cycles = 0;     // receiver hold-off left, owned by the ready process
  bit        hold_req = 1'b0;      // ask the ready process for the long hold-off
  bit        rx_busy_stalls = 1'b1;
  longint    cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(a*b / 2^sh), ties away from zero, saturated
  function automatic longint mul_rnd(longint a, longint b, int sh);
    logic [127:0] mag;
    logic [63:0]  ua, ub, lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    mag = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > {64'd0, lim}) mag = {64'd0, lim};
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // trunc(num * 2^24 / den) with den > 0, saturated to signed q8.24
  function automatic longint gain_quot(longint num, longint den);
    logic [127:0] q;
    logic [63:0]  n, lim;
    bit           neg;
    neg = num < 0;
    n   = neg ? -num : num;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q   = ({64'd0, n} << 24) / {64'd0, 64'(den)};
    if (q > {64'd0, lim}) q = {64'd0, lim};
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic filt_out_t filter_step(logic [31:0] z_in, logic [31:0] w_in,
                                            logic [15:0] dt_in);
    longint z, w, dt, rate, dtp, inner, s, k0, k1, y, p00, p01;
    filt_out_t r;
    z  = longint'(signed'(z_in));
    w  = longint'(signed'(w_in));
    dt = longint'(dt_in);
    // predict
    rate  = sat32(w - q_bias);
    q_ang = sat32(q_ang + mul_rnd(dt, rate, 16));
    dtp   = mul_rnd(dt, p_bb, 16);
    inner = sat32(dtp - p_ab - p_ba + n_ang);
    p_aa  = sat32(p_aa + mul_rnd(dt, inner, 16));
    p_ab  = sat32(p_ab - dtp);
    p_ba  = sat32(p_ba - dtp);
    p_bb  = sat32(p_bb + mul_rnd(n_bias, dt, 16));
    // gains, zeroed when the innovation variance is not positive
    s = p_aa + n_meas;
    r.fault = (s <= 0);
    k0 = r.fault ? 0 : gain_quot(p_aa, s);
    k1 = r.fault ? 0 : gain_quot(p_ba, s);
    // correct
    y      = sat32(z - q_ang);
    q_ang  = sat32(q_ang + mul_rnd(k0, y, 24));
    q_bias = sat32(q_bias + mul_rnd(k1, y, 24));
    p00 = p_aa;
    p01 = p_ab;
    p_aa = sat32(p_aa - mul_rnd(k0, p00, 24));
    p_ab = sat32(p_ab - mul_rnd(k0, p01, 24));
    p_ba = sat32(p_ba - mul_rnd(k1, p00, 24));
    p_bb = sat32(p_bb - mul_rnd(k1, p01, 24));
    r.angle = q_ang[31:0];
    r.bias  = q_bias[31:0];
    return r;
  endfunction

  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // offer one word, hold it until the filter takes it, then book the result
  task automatic send_sample(logic [31:0] z, logic [31:0] w, logic [15:0] dt,
                             bit gaps = 1'b1);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, w, z};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    expected_q.push_back(filter_step(z, w, dt));
    gap = gaps ? rand_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // only called with the filter idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[NOISE_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ANGLE_NOISE: n_ang  = longint'(val[NOISE_W-1:0]);
      REG_BIAS_NOISE:  n_bias = longint'(val[NOISE_W-1:0]);
      REG_MEAS_NOISE:  n_meas = longint'(val[NOISE_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_noise(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    wait_idle();
    write_reg(REG_ANGLE_NOISE, a);
    write_reg(REG_BIAS_NOISE, b);
    write_reg(REG_MEAS_NOISE, m);
  endtask

  // zero noise and zero time step keep the innovation variance at zero
  task automatic test_gain_fault();
    set_noise(32'd0, 32'd0, 32'd0);
    send_sample(32'h0001_0000, 32'h0002_0000, 16'd0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    set_noise({1'b0, {31{1'b1}}}, 32'd50332, 32'd503316);
    write_reg(REG_SPARE, 32'h7FFF_FFFF);   // must not disturb anything
  endtask

  task automatic test_field_extremes();
    logic [31:0] edge_vals [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    set_noise(32'd16777, 32'd50332, 32'd503316);
    foreach (edge_vals[i]) begin
      send_sample(edge_vals[i], edge_vals[3 - i], 16'hFFFF);
      send_sample(edge_vals[3 - i], edge_vals[i], 16'd0);
    end
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    send_sample(32'h8000_0000, 32'h0000_0000, 16'h8000);
    // all-max noise registers drive the covariance toward saturation
    set_noise({1'b0, {31{1'b1}}}, {1'b0, {31{1'b1}}}, {1'b0, {31{1'b1}}});
    repeat (6) send_sample($urandom, $urandom, 16'hFFFF);
  endtask

  // mostly plausible imu samples, some full-range noise
  task automatic test_random_phase(int n);
    logic [31:0] z, w;
    logic [15:0] dt;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        z  = 32'($signed($urandom_range(0, 180 << 16)) - (90 << 16));
        w  = 32'($signed($urandom_range(0, 500 << 16)) - (250 << 16));
        dt = 16'($urandom_range(30, 700));
      end else begin
        z  = $urandom;
        w  = $urandom;
        dt = 16'($urandom);
      end
      send_sample(z, w, dt);
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_sample($urandom, $urandom, 16'($urandom_range(0, 1000)), 1'b0);
  endtask

  // receiver ready: random stalls, a stretch of none, and the long hold-off
  always @(posedge clk_i) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (hold_req) begin
      hold_req = 1'b0;
      stall_cycles  <= LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles  <= stall_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_busy_stalls || pick < 60) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      if (pick > 96) stall_cycles <= $urandom_range(10, 50);
    end
  end

  // result checker, handshake sampled mid-cycle and taken at the next edge
  initial begin
    filt_out_t got, want;
    bit        hs;
    forever begin
      @(negedge clk_i);
      hs  = m_axis_tvalid && m_axis_tready;
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
      @(posedge clk_i);
      if (hs) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word angle=%h bias=%h fault=%b",
                   $time, got.angle, got.bias, got.fault);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.angle !== want.angle) begin
            $display("%0t: filtered_angle expected %h actual %h", $time, want.angle, got.angle);
            errors++;
          end
          if (got.bias !== want.bias) begin
            $display("%0t: estimated_bias expected %h actual %h", $time, want.bias, got.bias);
            errors++;
          end
          if (got.fault !== want.fault) begin
            $display("%0t: gain_fault expected %b actual %b", $time, want.fault, got.fault);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    q_ang = 0; q_bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
    n_ang = 16777; n_bias = 50332; n_meas = 503316;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_gain_fault();
    test_field_extremes();
    set_noise(32'd16777, 32'd50332, 32'd503316);
    test_random_phase(300);
    test_backpressure();
    set_noise(32'd0, 32'd0, 32'd1);
    rx_busy_stalls = 1'b0;               // a stretch with no receiver stalls
    test_random_phase(150);
    rx_busy_stalls = 1'b1;
    set_noise($urandom, $urandom, $urandom);
    test_random_phase(200);
    set_noise({1'b0, {31{1'b1}}}, {1'b0, {31{1'b1}}}, {1'b0, {31{1'b1}}});
    test_random_phase(150);
    set_noise($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
              $urandom_range(0, 1 << 22));
    test_random_phase(200);

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- angle_bias_kalman_filter.f -----
design/abkf_pkg.sv
design/abkf_mul.sv
design/abkf_div.sv
design/angle_bias_kalman_filter.sv
sim/angle_bias_kalman_filter_tb.sv
